[hw/rtl/rpu_pkg.sv]
// Shared types and constants for the RGB pair to UYVY alpha blend block.
`timescale 1ns / 1ps

package rpu_pkg;

    // One UYVY word, Cb in the lowest byte.
    typedef struct packed {
        logic [7:0] y1;
        logic [7:0] cr;
        logic [7:0] y0;
        logic [7:0] cb;
    } uyvy_t;

    // One overlay pixel, red in the lowest byte.
    typedef struct packed {
        logic [7:0] b;
        logic [7:0] g;
        logic [7:0] r;
    } rgb_t;

    // One input word: first pixel lowest, then second pixel, then the word under them.
    typedef struct packed {
        uyvy_t under;
        rgb_t  second;
        rgb_t  first;
    } pair_item_t;

    localparam int ITEM_W = $bits(pair_item_t);
    localparam int WORD_W = $bits(uyvy_t);

    localparam logic [7:0] ALPHA_RESET = 8'd220;
    localparam logic [7:0] ALPHA_FULL  = 8'd255;

    localparam logic [7:0] LUMA_MIN   = 8'd16;
    localparam logic [7:0] LUMA_MAX   = 8'd235;
    localparam logic [7:0] CHROMA_MIN = 8'd16;
    localparam logic [7:0] CHROMA_MAX = 8'd240;

endpackage

[hw/rtl/rpu_csc.sv]
// Two-stage BT.601 color space converter with 4:2:2 chroma averaging.
`timescale 1ns / 1ps

module rpu_csc (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               in_valid,
    output logic               in_ready,
    input  rpu_pkg::pair_item_t in_item,
    output logic               out_valid,
    input  logic               out_ready,
    output rpu_pkg::uyvy_t     out_fresh,
    output rpu_pkg::uyvy_t     out_under
);
    import rpu_pkg::*;

    localparam logic [15:0] Y_R = 16'd66;
    localparam logic [15:0] Y_G = 16'd129;
    localparam logic [15:0] Y_B = 16'd25;
    localparam logic [15:0] Y_RND = 16'd128;
    localparam logic signed [16:0] CB_R = -17'sd38;
    localparam logic signed [16:0] CB_G = -17'sd74;
    localparam logic signed [16:0] CB_B = 17'sd112;
    localparam logic signed [16:0] CR_R = 17'sd112;
    localparam logic signed [16:0] CR_G = -17'sd94;
    localparam logic signed [16:0] CR_B = -17'sd18;
    localparam logic signed [16:0] C_RND = 17'sd128;
    localparam logic signed [8:0] C_OFS = 9'sd128;

    function automatic logic [15:0] luma_sum(input rgb_t p);
        luma_sum = Y_R * {8'd0, p.r} + Y_G * {8'd0, p.g} + Y_B * {8'd0, p.b} + Y_RND;
    endfunction

    function automatic logic signed [16:0] chroma_sum(input rgb_t p,
                                                      input logic signed [16:0] kr,
                                                      input logic signed [16:0] kg,
                                                      input logic signed [16:0] kb);
        logic signed [16:0] sr;
        logic signed [16:0] sg;
        logic signed [16:0] sb;
        sr = signed'({9'd0, p.r});
        sg = signed'({9'd0, p.g});
        sb = signed'({9'd0, p.b});
        chroma_sum = kr * sr + kg * sg + kb * sb + C_RND;
    endfunction

    // Division by 256 that truncates toward zero, then the 128 offset.
    function automatic logic [7:0] chroma_byte(input logic signed [16:0] s);
        logic signed [8:0] q;
        logic signed [8:0] v;
        q = s[16:8];
        if (s[16] && (s[7:0] != 8'd0)) begin
            q = q + 9'sd1;
        end
        v = C_OFS + q;
        chroma_byte = v[7:0];
    endfunction

    // First stage: weighted sums.
    logic               sum_valid_reg;
    logic [15:0]        ys0_reg, ys1_reg;
    logic signed [16:0] bs0_reg, bs1_reg, rs0_reg, rs1_reg;
    uyvy_t              sum_under_reg;

    // Second stage: converted word.
    logic               cvt_valid_reg;
    uyvy_t              cvt_word_reg;
    uyvy_t              cvt_under_reg;
    uyvy_t              cvt_word_next;

    logic sum_en;
    logic cvt_en;

    logic [7:0] cb0, cb1, cr0, cr1;
    logic [8:0] cb_pair, cr_pair;

    assign cvt_en   = !cvt_valid_reg || out_ready;
    assign sum_en   = !sum_valid_reg || cvt_en;
    assign in_ready = sum_en;

    always_comb begin
        cb0 = chroma_byte(bs0_reg);
        cb1 = chroma_byte(bs1_reg);
        cr0 = chroma_byte(rs0_reg);
        cr1 = chroma_byte(rs1_reg);
        cb_pair = {1'b0, cb0} + {1'b0, cb1};
        cr_pair = {1'b0, cr0} + {1'b0, cr1};
        cvt_word_next.y0 = LUMA_MIN + ys0_reg[15:8];
        cvt_word_next.y1 = LUMA_MIN + ys1_reg[15:8];
        cvt_word_next.cb = cb_pair[8:1];
        cvt_word_next.cr = cr_pair[8:1];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sum_valid_reg <= 1'b0;
            cvt_valid_reg <= 1'b0;
        end else begin
            if (sum_en) begin
                sum_valid_reg <= in_valid;
            end
            if (cvt_en) begin
                cvt_valid_reg <= sum_valid_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (sum_en && in_valid) begin
            ys0_reg       <= luma_sum(in_item.first);
            ys1_reg       <= luma_sum(in_item.second);
            bs0_reg       <= chroma_sum(in_item.first, CB_R, CB_G, CB_B);
            bs1_reg       <= chroma_sum(in_item.second, CB_R, CB_G, CB_B);
            rs0_reg       <= chroma_sum(in_item.first, CR_R, CR_G, CR_B);
            rs1_reg       <= chroma_sum(in_item.second, CR_R, CR_G, CR_B);
            sum_under_reg <= in_item.under;
        end
        if (cvt_en && sum_valid_reg) begin
            cvt_word_reg  <= cvt_word_next;
            cvt_under_reg <= sum_under_reg;
        end
    end

    assign out_valid = cvt_valid_reg;
    assign out_fresh = cvt_word_reg;
    assign out_under = cvt_under_reg;

endmodule

[hw/rtl/rpu_blend.sv]
// Two-stage alpha blender of four bytes with an exact divide by 255.
`timescale 1ns / 1ps

module rpu_blend (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic [7:0]     alpha,
    input  logic           in_valid,
    output logic           in_ready,
    input  rpu_pkg::uyvy_t in_fresh,
    input  rpu_pkg::uyvy_t in_under,
    output logic           out_valid,
    input  logic           out_ready,
    output rpu_pkg::uyvy_t out_word
);
    import rpu_pkg::*;

    localparam int NUM_BYTES = WORD_W / 8;

    // Exact floor(p / 255) for any p up to 65025.
    function automatic logic [7:0] div255(input logic [15:0] p);
        logic [16:0] t;
        t = {1'b0, p} + {9'd0, p[15:8]} + 17'd1;
        div255 = t[15:8];
    endfunction

    logic                          mac_valid_reg;
    logic [NUM_BYTES-1:0][15:0]    mac_reg;
    logic [NUM_BYTES-1:0][15:0]    mac_next;
    logic                          out_valid_reg;
    logic [NUM_BYTES-1:0][7:0]     out_reg;
    logic [NUM_BYTES-1:0][7:0]     out_next;
    logic [7:0]                    alpha_inv;
    logic                          mac_en;
    logic                          out_en;

    assign out_en   = !out_valid_reg || out_ready;
    assign mac_en   = !mac_valid_reg || out_en;
    assign in_ready = mac_en;
    assign alpha_inv = ALPHA_FULL - alpha;

    always_comb begin
        for (int i = 0; i < NUM_BYTES; i++) begin
            mac_next[i] = {8'd0, in_fresh[i*8 +: 8]} * {8'd0, alpha}
                        + {8'd0, in_under[i*8 +: 8]} * {8'd0, alpha_inv};
            out_next[i] = div255(mac_reg[i]);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mac_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            if (mac_en) begin
                mac_valid_reg <= in_valid;
            end
            if (out_en) begin
                out_valid_reg <= mac_valid_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (mac_en && in_valid) begin
            mac_reg <= mac_next;
        end
        if (out_en && mac_valid_reg) begin
            out_reg <= out_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_word  = out_reg;

endmodule

[hw/rtl/rgb_pair_to_uyvy_alpha_blend_unit.sv]
// Top level of the RGB pair to UYVY converter and alpha blender.
`timescale 1ns / 1ps

// Each input word carries two adjacent overlay RGB pixels and the UYVY word
// that lies under them; each output word is that UYVY word blended with the
// BT.601 conversion of the overlay, the two chroma samples averaged.
// The opacity register (cfg_wr_en / cfg_wr_data) must be written by the user
// only while no word is in flight, which the block does not enforce; it resets to 220.
// The datapath is a four-stage pipeline: weighted RGB sums, scaling and
// chroma averaging, blend products, and the divide by 255 into the output
// register. While the receiver does not stall, throughput is one word per
// clock, set by the single pass of each word through the four stages.
// Every stage has its own valid bit and moves when the stage after it is
// empty or moving, so bubbles close up while the receiver stalls and
// s_axis_tready drops only once all four stages hold a word.
// A synchronous low aresetn empties the pipeline and restores the opacity.

module rgb_pair_to_uyvy_alpha_blend_unit (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_wr_en,
    input  logic [7:0]  cfg_wr_data,   // blend_alpha
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // red_first, green_first, blue_first, red_second, green_second,
    // blue_second, under_cb, under_luma_first, under_cr, under_luma_second
    input  logic [rpu_pkg::ITEM_W-1:0] s_axis_tdata,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // mixed_cb, mixed_luma_first, mixed_cr, mixed_luma_second
    output logic [rpu_pkg::WORD_W-1:0] m_axis_tdata
);
    import rpu_pkg::*;

    logic [7:0]  alpha_reg;
    pair_item_t  in_item;
    logic        csc_valid;
    logic        blend_ready;
    uyvy_t       csc_fresh;
    uyvy_t       csc_under;
    uyvy_t       blend_word;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            alpha_reg <= ALPHA_RESET;
        end else if (cfg_wr_en) begin
            alpha_reg <= cfg_wr_data;
        end
    end

    assign in_item = s_axis_tdata;

    rpu_csc u_csc (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_axis_tvalid),
        .in_ready  (s_axis_tready),
        .in_item   (in_item),
        .out_valid (csc_valid),
        .out_ready (blend_ready),
        .out_fresh (csc_fresh),
        .out_under (csc_under)
    );

    rpu_blend u_blend (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .alpha     (alpha_reg),
        .in_valid  (csc_valid),
        .in_ready  (blend_ready),
        .in_fresh  (csc_fresh),
        .in_under  (csc_under),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_word  (blend_word)
    );

    assign m_axis_tdata = blend_word;

    // Input backpressure only when the whole pipeline is full and the sink stalls.
    a_no_bubble_stall: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_axis_tready |-> csc_valid && !blend_ready && m_axis_tvalid && !m_axis_tready)
        else $error("input stalled while a pipeline stage is empty");

    a_blend_full_only: assert property (@(posedge aclk) disable iff (!aresetn)
        !blend_ready |-> m_axis_tvalid && !m_axis_tready)
        else $error("blend stage stalled without an output stall");

    // Converted samples stay inside the limited range.
    a_luma_range: assert property (@(posedge aclk) disable iff (!aresetn)
        csc_valid |-> csc_fresh.y0 >= LUMA_MIN && csc_fresh.y0 <= LUMA_MAX
                   && csc_fresh.y1 >= LUMA_MIN && csc_fresh.y1 <= LUMA_MAX)
        else $error("converted luma out of range");

    a_chroma_range: assert property (@(posedge aclk) disable iff (!aresetn)
        csc_valid |-> csc_fresh.cb >= CHROMA_MIN && csc_fresh.cb <= CHROMA_MAX
                   && csc_fresh.cr >= CHROMA_MIN && csc_fresh.cr <= CHROMA_MAX)
        else $error("converted chroma out of range");

endmodule
